FILE: src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Button panel controller package
// Shared types, register codes and defaults of the button panel controller.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int DEFAULT_CHANNELS  = 8;
  localparam int DEFAULT_TIME_BITS = 32;

  localparam int CFG_WIDTH    = 16;
  localparam int CFG_IDX_BITS = 2;

  // Number of debounce lanes and the lane of each button.
  localparam int NUM_BUTTONS = 4;
  localparam int BTN_PLUS    = 0;
  localparam int BTN_MINUS   = 1;
  localparam int BTN_SET     = 2;
  localparam int BTN_PWR     = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DEBOUNCE_TIME   = 2'd0,
    CFG_LONG_PRESS_TIME = 2'd1,
    CFG_BLINK_PERIOD    = 2'd2,
    CFG_WINDOW_TIMEOUT  = 2'd3
  } cfg_idx_e;

  localparam logic [CFG_WIDTH-1:0] RST_DEBOUNCE_TIME   = 16'd30;
  localparam logic [CFG_WIDTH-1:0] RST_LONG_PRESS_TIME = 16'd2000;
  localparam logic [CFG_WIDTH-1:0] RST_BLINK_PERIOD    = 16'd500;
  localparam logic [CFG_WIDTH-1:0] RST_WINDOW_TIMEOUT  = 16'd10000;

  localparam logic [1:0] MODE_RUN     = 2'd0;
  localparam logic [1:0] MODE_STANDBY = 2'd1;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        plus_level;
    logic        minus_level;
    logic        set_level;
    logic        power_level;
    logic [1:0]  power_mode;
    logic        blink_request;
  } in_item_t;

  typedef struct packed {
    logic       plus_pressed;
    logic       plus_released;
    logic       minus_pressed;
    logic       minus_released;
    logic       set_short;
    logic       set_long;
    logic       standby_enter;
    logic       standby_exit;
    logic       panel_window;
    logic       select_led;
    logic [2:0] selected_channel;
  } out_item_t;

  // What one debounce lane reports for the current tick.
  typedef struct packed {
    logic rose;      // debounced release accepted this tick
    logic fell;      // debounced press accepted this tick
    logic level;     // stable level after this tick
    logic long_hit;  // held level has lasted the long-press time
  } lane_evt_t;

endpackage

FILE: src/bpc_in_if.sv
// ----------------------------------------------------------------------------
// Scan tick channel
// Valid/ready channel carrying one scan tick of the button panel.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic               valid;
  logic               ready;
  bpc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/bpc_out_if.sv
// ----------------------------------------------------------------------------
// Panel result channel
// Valid/ready channel carrying one result of the button panel per tick.
// ----------------------------------------------------------------------------
interface bpc_out_if;
  logic               valid;
  logic               ready;
  bpc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/bpc_lane.sv
// ----------------------------------------------------------------------------
// Debounce lane
// Debounces one active-low button and measures how long its level is held.
// ----------------------------------------------------------------------------
module bpc_lane #(
  parameter int TIME_BITS = bpc_pkg::DEFAULT_TIME_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [TIME_BITS-1:0]           now_i,
  input  logic                           raw_i,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]  debounce_i,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]  long_press_i,
  output bpc_pkg::lane_evt_t             evt_o
);

  logic                 stable_q, stable_d;
  logic [TIME_BITS-1:0] match_q, match_d;
  logic [TIME_BITS-1:0] since_q, since_d;
  logic [TIME_BITS-1:0] match_diff, since_diff;
  logic                 rose, fell;

  assign match_diff = now_i - match_q;
  assign since_diff = now_i - since_q;

  always_comb begin
    stable_d = stable_q;
    match_d  = match_q;
    since_d  = since_q;
    rose     = 1'b0;
    fell     = 1'b0;
    if (raw_i != stable_q) begin
      if (match_diff >= TIME_BITS'(debounce_i)) begin
        stable_d = raw_i;
        since_d  = now_i;
        rose     = raw_i;
        fell     = ~raw_i;
      end
    end else begin
      match_d = now_i;
    end
  end

  always_comb begin
    evt_o.rose  = rose;
    evt_o.fell  = fell;
    evt_o.level = stable_d;
    // A level taken this tick has been held for zero time.
    if (rose || fell) begin
      evt_o.long_hit = (long_press_i == '0);
    end else begin
      evt_o.long_hit = (since_diff >= TIME_BITS'(long_press_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      match_q  <= '0;
      since_q  <= '0;
    end else if (accept_i) begin
      stable_q <= stable_d;
      match_q  <= match_d;
      since_q  <= since_d;
    end
  end

  a_stable_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(stable_q))
    else $error("debounced level changed without a tick");

  a_edge_matches_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_o.rose || evt_o.fell) |-> (evt_o.level == raw_i) && (stable_q != raw_i))
    else $error("debounce edge does not match the new level");

endmodule

FILE: src/bpc_panel.sv
// ----------------------------------------------------------------------------
// Panel merge stage
// Combines the four lane reports into press events, standby requests and the
// channel-selection window with its blinking LED.
// ----------------------------------------------------------------------------
module bpc_panel #(
  parameter int CHANNELS  = bpc_pkg::DEFAULT_CHANNELS,
  parameter int TIME_BITS = bpc_pkg::DEFAULT_TIME_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [TIME_BITS-1:0]           now_i,
  input  logic [1:0]                     mode_i,
  input  logic                           blink_req_i,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]  blink_period_i,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]  window_timeout_i,
  input  bpc_pkg::lane_evt_t             evt_i [bpc_pkg::NUM_BUTTONS],
  output bpc_pkg::out_item_t             res_o
);

  localparam int CH_BITS = $clog2(CHANNELS);
  localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(CHANNELS - 1);

  logic [1:0]           latch_q, latch_d;     // bit 0 SET, bit 1 PWR
  logic [CH_BITS-1:0]   ch_q, ch_d;
  logic                 win_q, win_d;
  logic                 led_q, led_d;
  logic [TIME_BITS-1:0] act_q, act_d;
  logic [TIME_BITS-1:0] blink_q, blink_d;
  logic [TIME_BITS-1:0] blink_diff, act_diff;
  logic                 run;
  bpc_pkg::lane_evt_t   e_plus, e_minus, e_set, e_pwr;

  assign blink_diff = now_i - blink_q;
  assign act_diff   = now_i - act_q;
  assign run        = (mode_i == bpc_pkg::MODE_RUN);
  assign e_plus     = evt_i[bpc_pkg::BTN_PLUS];
  assign e_minus    = evt_i[bpc_pkg::BTN_MINUS];
  assign e_set      = evt_i[bpc_pkg::BTN_SET];
  assign e_pwr      = evt_i[bpc_pkg::BTN_PWR];

  always_comb begin
    latch_d = latch_q;
    ch_d    = ch_q;
    win_d   = win_q;
    led_d   = led_q;
    act_d   = act_q;
    blink_d = blink_q;
    res_o   = '0;

    // Blink tick: rate limited to half the period; it also closes an idle window.
    if (blink_req_i && (blink_diff >= TIME_BITS'(blink_period_i >> 1))) begin
      blink_d = now_i;
      if (win_q && (act_diff >= TIME_BITS'(window_timeout_i))) begin
        win_d = 1'b0;
        led_d = 1'b0;
      end else if (win_q) begin
        led_d = ~led_q;
      end else begin
        led_d = 1'b0;
      end
    end

    // PWR is tracked in every power mode; standby entry acts only in run, exit only in standby.
    if (e_pwr.fell) latch_d[1] = 1'b1;
    if (!e_pwr.level && latch_d[1] && e_pwr.long_hit) begin
      latch_d[1] = 1'b0;
      if (run) begin
        res_o.standby_enter = 1'b1;
        win_d = 1'b0;
        led_d = 1'b0;
      end
    end
    if (e_pwr.rose && latch_d[1]) begin
      latch_d[1] = 1'b0;
      if (mode_i == bpc_pkg::MODE_STANDBY) res_o.standby_exit = 1'b1;
    end

    if (run) begin
      if (e_plus.fell) begin
        if (!win_d) begin
          win_d   = 1'b1;
          led_d   = 1'b1;
          act_d   = now_i;
          blink_d = now_i;
        end else begin
          ch_d  = (ch_d == CH_LAST) ? '0 : ch_d + CH_BITS'(1);
          act_d = now_i;
        end
        res_o.plus_pressed = 1'b1;
      end
      res_o.plus_released = e_plus.rose;

      if (e_minus.fell) begin
        if (!win_d) begin
          win_d   = 1'b1;
          led_d   = 1'b1;
          act_d   = now_i;
          blink_d = now_i;
        end else begin
          ch_d  = (ch_d == '0) ? CH_LAST : ch_d - CH_BITS'(1);
          act_d = now_i;
        end
        res_o.minus_pressed = 1'b1;
      end
      res_o.minus_released = e_minus.rose;

      if (e_set.fell) latch_d[0] = 1'b1;
      if (!e_set.level && latch_d[0] && e_set.long_hit) begin
        latch_d[0]     = 1'b0;
        res_o.set_long = 1'b1;
        win_d          = 1'b0;
        led_d          = 1'b0;
      end
      if (e_set.rose && latch_d[0]) begin
        latch_d[0] = 1'b0;
        if (!win_d) begin
          win_d   = 1'b1;
          led_d   = 1'b1;
          act_d   = now_i;
          blink_d = now_i;
        end else begin
          act_d           = now_i;
          res_o.set_short = 1'b1;
        end
      end
    end

    res_o.panel_window     = win_d;
    res_o.select_led       = led_d;
    res_o.selected_channel = 3'(ch_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      ch_q    <= '0;
      win_q   <= 1'b0;
      led_q   <= 1'b0;
      act_q   <= '0;
      blink_q <= '0;
    end else if (accept_i) begin
      latch_q <= latch_d;
      ch_q    <= ch_d;
      win_q   <= win_d;
      led_q   <= led_d;
      act_q   <= act_d;
      blink_q <= blink_d;
    end
  end

  a_led_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    led_q |-> win_q)
    else $error("selection LED lit with the window closed");

  a_channel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q <= CH_LAST)
    else $error("selected channel out of range");

  a_channel_moves_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !run) |-> (ch_d == ch_q))
    else $error("channel moved outside run mode");

endmodule

FILE: src/button_panel_controller_unit.sv
// ----------------------------------------------------------------------------
// Button panel controller
// Debounces four panel buttons, detects short and long presses and runs the
// channel-selection window.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one scan tick per request: timestamp, raw active-low button
//   levels, power mode and blink request. out_o returns exactly one result per
//   tick with the press events, standby requests, window flag, LED state and
//   selected channel after that tick.
//   Four debounce lanes work on the buttons side by side and the panel stage
//   merges their reports in the same cycle, so a tick is taken every cycle
//   while in_i.ready is high. The result is registered in the output
//   register. A second result register holds one more result while the
//   receiver stalls; in_i.ready drops only when both registers are full.
//   Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i
//   while no tick is in flight.
//   Reset clears all state but the result data: buttons released, window
//   closed, channel 0, and the registers take their default values.
// ----------------------------------------------------------------------------
module button_panel_controller_unit #(
  parameter int CHANNELS  = bpc_pkg::DEFAULT_CHANNELS,
  parameter int TIME_BITS = bpc_pkg::DEFAULT_TIME_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bpc_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::CFG_WIDTH-1:0]     cfg_wdata_i,
  bpc_in_if.sink                            in_i,
  bpc_out_if.source                         out_o
);

  logic [bpc_pkg::CFG_WIDTH-1:0] debounce_q, long_press_q, blink_period_q, timeout_q;
  logic                          accept, pop;
  logic [TIME_BITS-1:0]          now;
  logic [bpc_pkg::NUM_BUTTONS-1:0] raw;
  bpc_pkg::lane_evt_t            evt [bpc_pkg::NUM_BUTTONS];
  bpc_pkg::out_item_t            res;
  logic                          out_valid_q, skid_valid_q;
  bpc_pkg::out_item_t            out_data_q, skid_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= bpc_pkg::RST_DEBOUNCE_TIME;
      long_press_q   <= bpc_pkg::RST_LONG_PRESS_TIME;
      blink_period_q <= bpc_pkg::RST_BLINK_PERIOD;
      timeout_q      <= bpc_pkg::RST_WINDOW_TIMEOUT;
    end else if (cfg_we_i) begin
      case (bpc_pkg::cfg_idx_e'(cfg_idx_i))
        bpc_pkg::CFG_DEBOUNCE_TIME:   debounce_q     <= cfg_wdata_i;
        bpc_pkg::CFG_LONG_PRESS_TIME: long_press_q   <= cfg_wdata_i;
        bpc_pkg::CFG_BLINK_PERIOD:    blink_period_q <= cfg_wdata_i;
        bpc_pkg::CFG_WINDOW_TIMEOUT:  timeout_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = ~skid_valid_q;
  assign accept     = in_i.valid & ~skid_valid_q;
  assign pop        = out_valid_q & out_o.ready;
  assign now        = TIME_BITS'(in_i.data.time_ms);

  assign raw[bpc_pkg::BTN_PLUS]  = in_i.data.plus_level;
  assign raw[bpc_pkg::BTN_MINUS] = in_i.data.minus_level;
  assign raw[bpc_pkg::BTN_SET]   = in_i.data.set_level;
  assign raw[bpc_pkg::BTN_PWR]   = in_i.data.power_level;

  for (genvar b = 0; b < bpc_pkg::NUM_BUTTONS; b++) begin : g_lane
    bpc_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .accept_i     (accept),
      .now_i        (now),
      .raw_i        (raw[b]),
      .debounce_i   (debounce_q),
      .long_press_i (long_press_q),
      .evt_o        (evt[b])
    );
  end

  bpc_panel #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS)
  ) u_panel (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .now_i            (now),
    .mode_i           (in_i.data.power_mode),
    .blink_req_i      (in_i.data.blink_request),
    .blink_period_i   (blink_period_q),
    .window_timeout_i (timeout_q),
    .evt_i            (evt),
    .res_o            (res)
  );

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!out_valid_q || pop) begin
        out_data_q <= res;
      end else begin
        skid_data_q <= res;
      end
    end else if (pop && skid_valid_q) begin
      out_data_q <= skid_data_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  a_skid_behind_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && out_valid_q && !out_o.ready) |=> skid_valid_q)
    else $error("request taken during a stall was not kept");

  a_result_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

endmodule

FILE: test/button_panel_controller_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button panel controller testbench
// Sends scan ticks through the request channel with random gaps and random
// receiver stalls. A scoreboard keeps its own model of the debounce lanes,
// the press latches and the selection window, and compares every report
// field by field. The run covers directed corner ticks and then random press
// gestures, blink stretches and noise under several register settings.
// ----------------------------------------------------------------------------
module button_panel_controller_unit_test;

  localparam int NCH = bpc_pkg::DEFAULT_CHANNELS;
  localparam logic [1:0] MODE_OTHER = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int LATCH_SET = 0;
  localparam int LATCH_PWR = 1;
  localparam logic [3:0] ALL_UP = 4'hF;

  class panel_scoreboard;
    typedef struct packed {
      logic fell;
      logic rose;
    } lane_edges_t;

    logic [15:0] debounce_len, long_ms, blink_ms, timeout_ms;
    logic [3:0]  stable;
    logic [31:0] match_t [bpc_pkg::NUM_BUTTONS];
    logic [31:0] since_t [bpc_pkg::NUM_BUTTONS];
    logic [1:0]  latched;
    int unsigned chan;
    bit          window, led;
    logic [31:0] activity_t, blink_t;
    bpc_pkg::out_item_t awaited_reports [$];
    int          errors;

    function new();
      debounce_len = bpc_pkg::RST_DEBOUNCE_TIME;
      long_ms      = bpc_pkg::RST_LONG_PRESS_TIME;
      blink_ms     = bpc_pkg::RST_BLINK_PERIOD;
      timeout_ms   = bpc_pkg::RST_WINDOW_TIMEOUT;
      stable       = ALL_UP;
      foreach (match_t[i]) begin
        match_t[i] = '0;
        since_t[i] = '0;
      end
      latched    = '0;
      chan       = 0;
      window     = 1'b0;
      led        = 1'b0;
      activity_t = '0;
      blink_t    = '0;
      errors     = 0;
    endfunction

    function void set_register(bpc_pkg::cfg_idx_e idx, logic [15:0] v);
      case (idx)
        bpc_pkg::CFG_DEBOUNCE_TIME:   debounce_len = v;
        bpc_pkg::CFG_LONG_PRESS_TIME: long_ms = v;
        bpc_pkg::CFG_BLINK_PERIOD:    blink_ms = v;
        bpc_pkg::CFG_WINDOW_TIMEOUT:  timeout_ms = v;
        default: ;
      endcase
    endfunction

    function void open_window(logic [31:0] now);
      window     = 1'b1;
      activity_t = now;
      led        = 1'b1;
      blink_t    = now;
    endfunction

    function void close_window();
      window = 1'b0;
      led    = 1'b0;
    endfunction

    function lane_edges_t debounce_lane(int b, logic level, logic [31:0] now);
      lane_edges_t e;
      e = '0;
      if (level != stable[b]) begin
        if ((now - match_t[b]) >= 32'(debounce_len)) begin
          stable[b]  = level;
          since_t[b] = now;
          if (level) e.rose = 1'b1;
          else e.fell = 1'b1;
        end
      end else begin
        match_t[b] = now;
      end
      return e;
    endfunction

    function bpc_pkg::out_item_t predict_panel(bpc_pkg::in_item_t it);
      logic [31:0] now;
      logic [3:0]  raw;
      bit          run;
      lane_edges_t e [bpc_pkg::NUM_BUTTONS];
      bpc_pkg::out_item_t r;
      now = it.time_ms;
      run = (it.power_mode == bpc_pkg::MODE_RUN);
      raw = {it.power_level, it.set_level, it.minus_level, it.plus_level};
      r   = '0;

      // A blink request that comes too early is simply dropped.
      if (it.blink_request && (now - blink_t) >= 32'(blink_ms >> 1)) begin
        blink_t = now;
        if (window && (now - activity_t) >= 32'(timeout_ms)) close_window();
        else if (window) led = !led;
        else led = 1'b0;
      end

      for (int k = 0; k < bpc_pkg::NUM_BUTTONS; k++) e[k] = debounce_lane(k, raw[k], now);

      if (e[bpc_pkg::BTN_PWR].fell) latched[LATCH_PWR] = 1'b1;
      if (!stable[bpc_pkg::BTN_PWR] && latched[LATCH_PWR] &&
          (now - since_t[bpc_pkg::BTN_PWR]) >= 32'(long_ms)) begin
        latched[LATCH_PWR] = 1'b0;
        if (run) begin
          r.standby_enter = 1'b1;
          close_window();
        end
      end
      if (e[bpc_pkg::BTN_PWR].rose && latched[LATCH_PWR]) begin
        latched[LATCH_PWR] = 1'b0;
        if (it.power_mode == bpc_pkg::MODE_STANDBY) r.standby_exit = 1'b1;
      end

      if (run) begin
        if (e[bpc_pkg::BTN_PLUS].fell) begin
          if (!window) open_window(now);
          else begin
            chan = (chan + 1) % NCH;
            activity_t = now;
          end
          r.plus_pressed = 1'b1;
        end
        r.plus_released = e[bpc_pkg::BTN_PLUS].rose;
        if (e[bpc_pkg::BTN_MINUS].fell) begin
          if (!window) open_window(now);
          else begin
            chan = (chan + NCH - 1) % NCH;
            activity_t = now;
          end
          r.minus_pressed = 1'b1;
        end
        r.minus_released = e[bpc_pkg::BTN_MINUS].rose;

        if (e[bpc_pkg::BTN_SET].fell) latched[LATCH_SET] = 1'b1;
        if (!stable[bpc_pkg::BTN_SET] && latched[LATCH_SET] &&
            (now - since_t[bpc_pkg::BTN_SET]) >= 32'(long_ms)) begin
          latched[LATCH_SET] = 1'b0;
          r.set_long = 1'b1;
          close_window();
        end
        if (e[bpc_pkg::BTN_SET].rose && latched[LATCH_SET]) begin
          latched[LATCH_SET] = 1'b0;
          if (!window) open_window(now);
          else begin
            activity_t = now;
            r.set_short = 1'b1;
          end
        end
      end

      r.panel_window     = window;
      r.select_led       = led;
      r.selected_channel = 3'(chan);
      return r;
    endfunction

    function void note_scan_tick(bpc_pkg::in_item_t it);
      awaited_reports.push_back(predict_panel(it));
    endfunction

    function void check_panel_report(bpc_pkg::out_item_t got);
      string       flag_name [10] = '{"plus_pressed", "plus_released", "minus_pressed",
                                      "minus_released", "set_short", "set_long",
                                      "standby_enter", "standby_exit", "panel_window",
                                      "select_led"};
      bpc_pkg::out_item_t want;
      logic [12:0] w, g;
      if (awaited_reports.size() == 0) begin
        $display("%0t: report with none outstanding, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = awaited_reports.pop_front();
      w = want;
      g = got;
      // The ten flags sit above the channel index in the packed report.
      for (int i = 0; i < 10; i++) begin
        if (w[12-i] !== g[12-i]) begin
          $display("%0t: %s expected %0d, actual %0d", $time, flag_name[i], w[12-i], g[12-i]);
          errors++;
        end
      end
      if (want.selected_channel !== got.selected_channel) begin
        $display("%0t: selected_channel expected %0d, actual %0d", $time,
                 want.selected_channel, got.selected_channel);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  bpc_pkg::cfg_idx_e cfg_idx;
  logic [15:0] cfg_wdata;
  bit          idle_on = 1'b1;
  logic [31:0] cur_time;
  int unsigned sent = 0;

  panel_scoreboard sb = new();

  bpc_in_if  scan_if ();
  bpc_out_if report_if ();

  button_panel_controller_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (scan_if),
    .out_o       (report_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (report_if.valid && report_if.ready) sb.check_panel_report(report_if.data);
      if (scan_if.valid && scan_if.ready) sb.note_scan_tick(scan_if.data);
    end
  end

  // Receiver side: random stall bursts.
  initial begin : receiver
    int unsigned hold_off;
    hold_off = 0;
    report_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        report_if.ready = 1'b1;
      end else if (hold_off != 0) begin
        report_if.ready = 1'b0;
        hold_off--;
      end else if ($urandom_range(0, 5) == 0) begin
        report_if.ready = 1'b0;
        hold_off = $urandom_range(0, 3);
      end else begin
        report_if.ready = 1'b1;
      end
    end
  end

  // Levels are packed as {power, set, minus, plus}, all active low.
  task automatic tick(logic [31:0] t, logic [3:0] lv, logic [1:0] mode, bit blink);
    bpc_pkg::in_item_t it;
    it.time_ms       = t;
    it.plus_level    = lv[bpc_pkg::BTN_PLUS];
    it.minus_level   = lv[bpc_pkg::BTN_MINUS];
    it.set_level     = lv[bpc_pkg::BTN_SET];
    it.power_level   = lv[bpc_pkg::BTN_PWR];
    it.power_mode    = mode;
    it.blink_request = blink;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      scan_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    scan_if.valid = 1'b1;
    scan_if.data  = it;
    do @(posedge clk); while (!scan_if.ready);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    scan_if.valid = 1'b0;
    while (sb.awaited_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(bpc_pkg::cfg_idx_e idx, logic [15:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = v;
    @(posedge clk);
    sb.set_register(idx, v);
  endtask

  task automatic program_panel(logic [15:0] d, logic [15:0] l, logic [15:0] b,
                               logic [15:0] w);
    drain();
    write_register(bpc_pkg::CFG_DEBOUNCE_TIME, d);
    write_register(bpc_pkg::CFG_LONG_PRESS_TIME, l);
    write_register(bpc_pkg::CFG_BLINK_PERIOD, b);
    write_register(bpc_pkg::CFG_WINDOW_TIMEOUT, w);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One button held for a short, medium or long time, with contact bounce,
  // sometimes together with a second button, and then released.
  task automatic press_gesture();
    int unsigned deb, lng, hold, span, step, adv, elapsed, b, b2;
    logic [3:0]  lv;
    logic [1:0]  mode;
    bit          chord;
    deb   = sb.debounce_len;
    lng   = sb.long_ms;
    b     = $urandom_range(0, 3);
    b2    = $urandom_range(0, 3);
    chord = ($urandom_range(0, 7) == 0);
    mode  = ($urandom_range(0, 3) != 0) ? bpc_pkg::MODE_RUN : 2'($urandom_range(1, 3));
    case ($urandom_range(0, 2))
      0:       hold = $urandom_range(0, deb + deb / 2 + 1);
      1:       hold = deb + $urandom_range(0, lng);
      default: hold = deb + lng + $urandom_range(0, lng / 2 + 10);
    endcase
    step    = hold / $urandom_range(3, 20);
    elapsed = 0;
    do begin
      lv = ALL_UP;
      lv[b] = 1'b0;
      if (chord) lv[b2] = 1'b0;
      if (elapsed < deb && $urandom_range(0, 3) == 0) lv[b] = 1'b1;
      tick(cur_time, lv, mode, $urandom_range(0, 3) == 0);
      adv = $urandom_range(step / 2, step + step / 2 + 1);
      cur_time += adv;
      elapsed  += adv;
    end while (elapsed <= hold);
    span    = deb + $urandom_range(1, deb / 2 + 5);
    step    = span / $urandom_range(2, 6);
    elapsed = 0;
    do begin
      lv = ALL_UP;
      if (elapsed < deb / 2 && $urandom_range(0, 3) == 0) lv[b] = 1'b0;
      tick(cur_time, lv, mode, $urandom_range(0, 3) == 0);
      adv = $urandom_range(step / 2, step + step / 2 + 1);
      cur_time += adv;
      elapsed  += adv;
    end while (elapsed <= span);
  endtask

  // Idle panel with blink requests around the rate limit and the timeout.
  task automatic blink_stretch();
    int unsigned n, half;
    n    = $urandom_range(3, 10);
    half = sb.blink_ms / 2;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 5))
        0:       cur_time += half;
        1:       cur_time += (half > 0) ? half - 1 : 0;
        2:       cur_time += $urandom_range(0, half);
        3:       cur_time += sb.timeout_ms + $urandom_range(0, 2);
        default: cur_time += $urandom_range(half, sb.blink_ms + 1);
      endcase
      tick(cur_time, ALL_UP, ($urandom_range(0, 7) == 0) ? MODE_OTHER : bpc_pkg::MODE_RUN,
           $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 5) == 0) cur_time = $urandom();
      else cur_time += $urandom_range(0, 2 * sb.debounce_len + 10);
      tick(cur_time, 4'($urandom()), 2'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic random_phase(int unsigned n, bit idle);
    int unsigned first;
    idle_on = idle;
    first   = sent;
    while (sent - first < n) begin
      case ($urandom_range(0, 9))
        0, 1:    blink_stretch();
        2:       noise_burst();
        default: press_gesture();
      endcase
    end
  endtask

  initial begin : stimulus
    scan_if.valid = 1'b0;
    scan_if.data  = '0;
    cfg_we        = 1'b0;
    cfg_idx       = bpc_pkg::CFG_DEBOUNCE_TIME;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed ticks under the reset settings.
    tick(32'd0, ALL_UP, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd10, 4'hE, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd40, 4'hE, bpc_pkg::MODE_RUN, 1'b0);      // PLUS accepted, window opens
    tick(32'd45, ALL_UP, bpc_pkg::MODE_RUN, 1'b1);    // early blink is dropped
    tick(32'd100, 4'hD, bpc_pkg::MODE_RUN, 1'b0);     // MINUS wraps down to the top
    tick(32'd140, ALL_UP, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd200, 4'hE, bpc_pkg::MODE_RUN, 1'b0);     // PLUS wraps back to zero
    tick(32'd240, ALL_UP, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd400, 4'hB, bpc_pkg::MODE_RUN, 1'b1);
    tick(32'd500, ALL_UP, bpc_pkg::MODE_RUN, 1'b0);   // short SET in the open window reports set_short
    tick(32'd600, 4'hB, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd2700, 4'hB, bpc_pkg::MODE_RUN, 1'b0);    // long SET
    tick(32'd2800, ALL_UP, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd3000, 4'h7, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd5100, 4'h7, bpc_pkg::MODE_RUN, 1'b0);    // long PWR asks for standby
    tick(32'd5200, ALL_UP, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd6000, 4'h7, bpc_pkg::MODE_STANDBY, 1'b0);
    tick(32'd6100, ALL_UP, bpc_pkg::MODE_STANDBY, 1'b0);
    tick(32'd6200, 4'hE, MODE_SPARE, 1'b0);
    tick(32'd6300, ALL_UP, MODE_OTHER, 1'b0);
    tick(32'd6400, 4'h7, MODE_OTHER, 1'b0);
    tick(32'd8500, 4'h7, MODE_OTHER, 1'b0);  // long PWR outside run mode
    tick(32'd8600, ALL_UP, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd8700, 4'hE, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd8800, ALL_UP, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'd18900, ALL_UP, bpc_pkg::MODE_RUN, 1'b1); // blink after the window timeout
    tick(32'hFFFF_FFF0, ALL_UP, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'hFFFF_FFF8, 4'hE, bpc_pkg::MODE_RUN, 1'b0);
    tick(32'h0000_0010, 4'hE, bpc_pkg::MODE_RUN, 1'b0); // debounce across the wrap
    tick(32'h0000_0040, 4'h0, bpc_pkg::MODE_RUN, 1'b1);
    cur_time = 32'h0000_0040;

    random_phase(160, 1'b1);
    program_panel(16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(180, 1'b1);
    program_panel(16'($urandom_range(1, 20)), 16'($urandom_range(20, 200)),
                  16'($urandom_range(2, 100)), 16'($urandom_range(50, 800)));
    cur_time = 32'hFFFF_FF00;
    random_phase(180, 1'b1);
    program_panel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(180, 1'b1);
    program_panel(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    random_phase(180, 1'b1);
    program_panel(bpc_pkg::RST_DEBOUNCE_TIME, bpc_pkg::RST_LONG_PRESS_TIME,
                  bpc_pkg::RST_BLINK_PERIOD, bpc_pkg::RST_WINDOW_TIMEOUT);
    random_phase(180, 1'b0);
    drain();

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
